// ===== hw/rtl/segment_pair_collision_test_macros.svh =====
// ----------------------------------------------------------------------------
// Segment pair collision test: assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_COLLISION_TEST_MACROS_SVH
`define SEGMENT_PAIR_COLLISION_TEST_MACROS_SVH

// same-cycle implication
`define SPCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/spct_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment pair collision test: package
// Widths, codes, payload types and helper functions.
// ----------------------------------------------------------------------------
package spct_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int DET_W      = PROD_W + 1;
	localparam int DET_TOL_W  = 35;
	localparam int BOX_TOL_W  = 16;
	localparam int CFG_DATA_W = 35;
	localparam int CMP_W      = (DET_W > DET_TOL_W) ? DET_W : DET_TOL_W;
	localparam int BOX_W      = ((COORD_BITS > BOX_TOL_W) ? COORD_BITS : BOX_TOL_W) + 2;
	localparam int N_ORIENT   = 4;

	localparam logic CFG_DET_TOL = 1'b0;
	localparam logic CFG_BOX_TOL = 1'b1;

	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_CROSS    = 3'd1;
	localparam logic [2:0] KIND_B0_ON_A  = 3'd2;
	localparam logic [2:0] KIND_B1_ON_A  = 3'd3;
	localparam logic [2:0] KIND_A0_ON_B  = 3'd4;
	localparam logic [2:0] KIND_A1_ON_B  = 3'd5;

	typedef enum logic [1:0] {
		ORI_COL = 2'd0,
		ORI_CW  = 2'd1,
		ORI_CCW = 2'd2
	} orient_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t ax0;
		coord_t ay0;
		coord_t ax1;
		coord_t ay1;
		coord_t bx0;
		coord_t by0;
		coord_t bx1;
		coord_t by1;
	} seg_pair_t;

	typedef struct packed {
		logic [N_ORIENT-1:0][PROD_W-1:0] pa;
		logic [N_ORIENT-1:0][PROD_W-1:0] pb;
		logic [N_ORIENT-1:0]             on_box;
	} prod_t;

	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} pipe_ctl_t;

	function automatic logic signed [DIFF_W-1:0] diff(input coord_t a, input coord_t b);
		logic signed [DIFF_W-1:0] ea;
		logic signed [DIFF_W-1:0] eb;
		ea = DIFF_W'(a);
		eb = DIFF_W'(b);
		return ea - eb;
	endfunction

	function automatic logic [PROD_W-1:0] mul(input logic signed [DIFF_W-1:0] a,
			input logic signed [DIFF_W-1:0] b);
		logic signed [PROD_W-1:0] ea;
		logic signed [PROD_W-1:0] eb;
		ea = PROD_W'(a);
		eb = PROD_W'(b);
		return ea * eb;
	endfunction

	// q inside the box of p and r, widened by tol on every side
	function automatic logic in_box(input coord_t px, input coord_t py, input coord_t qx,
			input coord_t qy, input coord_t rx, input coord_t ry,
			input logic [BOX_TOL_W-1:0] tol);
		logic signed [BOX_W-1:0] t;
		logic signed [BOX_W-1:0] lo_x;
		logic signed [BOX_W-1:0] hi_x;
		logic signed [BOX_W-1:0] lo_y;
		logic signed [BOX_W-1:0] hi_y;
		logic signed [BOX_W-1:0] ex;
		logic signed [BOX_W-1:0] ey;
		t    = $signed({{(BOX_W-BOX_TOL_W){1'b0}}, tol});
		lo_x = (px > rx) ? BOX_W'(rx) : BOX_W'(px);
		hi_x = (px > rx) ? BOX_W'(px) : BOX_W'(rx);
		lo_y = (py > ry) ? BOX_W'(ry) : BOX_W'(py);
		hi_y = (py > ry) ? BOX_W'(py) : BOX_W'(ry);
		ex   = BOX_W'(qx);
		ey   = BOX_W'(qy);
		return (ex <= hi_x + t) && (ex >= lo_x - t) && (ey <= hi_y + t) && (ey >= lo_y - t);
	endfunction

	function automatic orient_t orient_class(input logic [PROD_W-1:0] pa,
			input logic [PROD_W-1:0] pb, input logic [DET_TOL_W-1:0] tol);
		logic signed [DET_W-1:0] det;
		logic [DET_W-1:0]        mag;
		logic [CMP_W-1:0]        mag_w;
		logic [CMP_W-1:0]        tol_w;
		orient_t                 res;
		det   = DET_W'($signed(pa)) - DET_W'($signed(pb));
		mag   = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
		mag_w = CMP_W'(mag);
		tol_w = CMP_W'(tol);
		if (det == '0) begin
			res = ORI_COL;
		end else if (mag_w < tol_w) begin
			res = ORI_COL;
		end else if (det[DET_W-1]) begin
			res = ORI_CCW;
		end else begin
			res = ORI_CW;
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/spct_products.sv =====
// ----------------------------------------------------------------------------
// Segment pair collision test: product stage
// Edge differences, determinant partial products and widened box tests.
// ----------------------------------------------------------------------------
module spct_products (
	input  logic                               clk,
	input  spct_pkg::seg_pair_t                seg_s1,
	input  logic [spct_pkg::BOX_TOL_W-1:0]     box_tol,
	input  spct_pkg::pipe_ctl_t                ctl,
	output spct_pkg::prod_t                    prod_s2
);

	logic signed [spct_pkg::DIFF_W-1:0] da_x;
	logic signed [spct_pkg::DIFF_W-1:0] da_y;
	logic signed [spct_pkg::DIFF_W-1:0] db_x;
	logic signed [spct_pkg::DIFF_W-1:0] db_y;
	spct_pkg::prod_t                    prod_d;

	always_comb begin
		da_x = spct_pkg::diff(seg_s1.ax1, seg_s1.ax0);
		da_y = spct_pkg::diff(seg_s1.ay1, seg_s1.ay0);
		db_x = spct_pkg::diff(seg_s1.bx1, seg_s1.bx0);
		db_y = spct_pkg::diff(seg_s1.by1, seg_s1.by0);

		// (A0, A1, B0)
		prod_d.pa[0] = spct_pkg::mul(da_y, spct_pkg::diff(seg_s1.bx0, seg_s1.ax1));
		prod_d.pb[0] = spct_pkg::mul(da_x, spct_pkg::diff(seg_s1.by0, seg_s1.ay1));
		// (A0, A1, B1)
		prod_d.pa[1] = spct_pkg::mul(da_y, spct_pkg::diff(seg_s1.bx1, seg_s1.ax1));
		prod_d.pb[1] = spct_pkg::mul(da_x, spct_pkg::diff(seg_s1.by1, seg_s1.ay1));
		// (B0, B1, A0)
		prod_d.pa[2] = spct_pkg::mul(db_y, spct_pkg::diff(seg_s1.ax0, seg_s1.bx1));
		prod_d.pb[2] = spct_pkg::mul(db_x, spct_pkg::diff(seg_s1.ay0, seg_s1.by1));
		// (B0, B1, A1)
		prod_d.pa[3] = spct_pkg::mul(db_y, spct_pkg::diff(seg_s1.ax1, seg_s1.bx1));
		prod_d.pb[3] = spct_pkg::mul(db_x, spct_pkg::diff(seg_s1.ay1, seg_s1.by1));

		prod_d.on_box[0] = spct_pkg::in_box(seg_s1.ax0, seg_s1.ay0, seg_s1.bx0, seg_s1.by0,
			seg_s1.ax1, seg_s1.ay1, box_tol);
		prod_d.on_box[1] = spct_pkg::in_box(seg_s1.ax0, seg_s1.ay0, seg_s1.bx1, seg_s1.by1,
			seg_s1.ax1, seg_s1.ay1, box_tol);
		prod_d.on_box[2] = spct_pkg::in_box(seg_s1.bx0, seg_s1.by0, seg_s1.ax0, seg_s1.ay0,
			seg_s1.bx1, seg_s1.by1, box_tol);
		prod_d.on_box[3] = spct_pkg::in_box(seg_s1.bx0, seg_s1.by0, seg_s1.ax1, seg_s1.ay1,
			seg_s1.bx1, seg_s1.by1, box_tol);
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			prod_s2 <= prod_d;
		end
	end

endmodule

// ===== hw/rtl/spct_decide.sv =====
// ----------------------------------------------------------------------------
// Segment pair collision test: decision stage
// Determinants, orientation classes and contact selection into the result register.
// ----------------------------------------------------------------------------
module spct_decide (
	input  logic                               clk,
	input  spct_pkg::prod_t                    prod_s2,
	input  logic [spct_pkg::DET_TOL_W-1:0]     det_tol,
	input  spct_pkg::pipe_ctl_t                ctl,
	output logic                               hit_s3,
	output logic [2:0]                         kind_s3
);

	spct_pkg::orient_t [spct_pkg::N_ORIENT-1:0] ori;
	logic [2:0]                                 kind_d;

	always_comb begin
		for (int i = 0; i < spct_pkg::N_ORIENT; i++) begin
			ori[i] = spct_pkg::orient_class(prod_s2.pa[i], prod_s2.pb[i], det_tol);
		end

		if (ori[0] != ori[1] && ori[2] != ori[3]) begin
			kind_d = spct_pkg::KIND_CROSS;
		end else if (ori[0] == spct_pkg::ORI_COL && prod_s2.on_box[0]) begin
			kind_d = spct_pkg::KIND_B0_ON_A;
		end else if (ori[1] == spct_pkg::ORI_COL && prod_s2.on_box[1]) begin
			kind_d = spct_pkg::KIND_B1_ON_A;
		end else if (ori[2] == spct_pkg::ORI_COL && prod_s2.on_box[2]) begin
			kind_d = spct_pkg::KIND_A0_ON_B;
		end else if (ori[3] == spct_pkg::ORI_COL && prod_s2.on_box[3]) begin
			kind_d = spct_pkg::KIND_A1_ON_B;
		end else begin
			kind_d = spct_pkg::KIND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			kind_s3 <= kind_d;
			hit_s3  <= (kind_d != spct_pkg::KIND_NONE);
		end
	end

endmodule

// ===== hw/rtl/segment_pair_collision_test.sv =====
// ----------------------------------------------------------------------------
// Segment pair collision test: top level
// Result: a request accepted into the input stage passes the products and result registers.
// Throughput: one request per cycle while the output is not stalled; three register stages (input, products,
// result) advance independently, so bubbles close up under output stall.
// Reset: pipeline valids and both tolerance registers clear to zero.
// ----------------------------------------------------------------------------
`include "segment_pair_collision_test_macros.svh"

module segment_pair_collision_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic                                cfg_index,
	input  logic [spct_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [spct_pkg::COORD_BITS-1:0] a_start_x,
	input  logic signed [spct_pkg::COORD_BITS-1:0] a_start_y,
	input  logic signed [spct_pkg::COORD_BITS-1:0] a_end_x,
	input  logic signed [spct_pkg::COORD_BITS-1:0] a_end_y,
	input  logic signed [spct_pkg::COORD_BITS-1:0] b_start_x,
	input  logic signed [spct_pkg::COORD_BITS-1:0] b_start_y,
	input  logic signed [spct_pkg::COORD_BITS-1:0] b_end_x,
	input  logic signed [spct_pkg::COORD_BITS-1:0] b_end_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic [2:0]                          contact_kind
);

	logic [spct_pkg::DET_TOL_W-1:0] det_tol_q;
	logic [spct_pkg::BOX_TOL_W-1:0] box_tol_q;
	spct_pkg::seg_pair_t            seg_s1;
	spct_pkg::prod_t                prod_s2;
	spct_pkg::pipe_ctl_t            ctl;
	logic                           valid_s1;
	logic                           valid_s2;
	logic                           valid_s3;
	logic                           adv_s3;
	logic                           ready_s2;
	logic                           ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_tol_q <= '0;
			box_tol_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				spct_pkg::CFG_DET_TOL: det_tol_q <= cfg_data[spct_pkg::DET_TOL_W-1:0];
				spct_pkg::CFG_BOX_TOL: box_tol_q <= cfg_data[spct_pkg::BOX_TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s3      = !(valid_s3 && out_stall);
	assign ready_s2    = !valid_s2 || adv_s3;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign in_stall    = !ready_s1;
	assign ctl.load_s2 = valid_s1 && ready_s2;
	assign ctl.load_s3 = valid_s2 && adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			seg_s1.ax0 <= a_start_x;
			seg_s1.ay0 <= a_start_y;
			seg_s1.ax1 <= a_end_x;
			seg_s1.ay1 <= a_end_y;
			seg_s1.bx0 <= b_start_x;
			seg_s1.by0 <= b_start_y;
			seg_s1.bx1 <= b_end_x;
			seg_s1.by1 <= b_end_y;
		end
	end

	spct_products u_products (
		.clk     (clk),
		.seg_s1  (seg_s1),
		.box_tol (box_tol_q),
		.ctl     (ctl),
		.prod_s2 (prod_s2)
	);

	spct_decide u_decide (
		.clk     (clk),
		.prod_s2 (prod_s2),
		.det_tol (det_tol_q),
		.ctl     (ctl),
		.hit_s3  (hit),
		.kind_s3 (contact_kind)
	);

	assign out_valid = valid_s3;

	`SPCT_ASSERT_NOW(a_hit_matches_kind, out_valid, hit == (contact_kind != spct_pkg::KIND_NONE), "hit disagrees with contact_kind")
	`SPCT_ASSERT_NOW(a_kind_in_range, out_valid, contact_kind <= spct_pkg::KIND_A1_ON_B, "contact_kind out of range")
	`SPCT_ASSERT_NOW(a_stall_only_when_full, in_stall, valid_s1 && valid_s2 && valid_s3, "input stalled with a free stage")
	`SPCT_ASSERT_NEXT(a_s2_held_under_stall, valid_s2 && valid_s3 && out_stall, valid_s2, "request lost from product stage")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pair collision test: testbench
// Streams segment pairs through the block under several tolerance settings,
// with random idling on both sides and one long output hold-off. Every result
// is compared against an integer orientation/bounding-box predictor.
// ----------------------------------------------------------------------------
module tb;
	import spct_pkg::*;

	localparam int HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 500000;

	class contact_scoreboard;
		longint     det_tol;
		longint     box_tol;
		logic [2:0] pending_kinds[$];
		int         errors;

		function orient_t orientation(longint px, longint py, longint qx, longint qy,
				longint rx, longint ry);
			longint det;
			longint mag;
			det = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
			mag = (det < 0) ? -det : det;
			if (det == 0 || mag < det_tol) return ORI_COL;
			return (det > 0) ? ORI_CW : ORI_CCW;
		endfunction

		function bit near_box(longint px, longint py, longint qx, longint qy,
				longint rx, longint ry);
			longint lo_x;
			longint hi_x;
			longint lo_y;
			longint hi_y;
			lo_x = (px > rx) ? rx : px;
			hi_x = (px > rx) ? px : rx;
			lo_y = (py > ry) ? ry : py;
			hi_y = (py > ry) ? py : ry;
			return qx <= hi_x + box_tol && qx >= lo_x - box_tol &&
				qy <= hi_y + box_tol && qy >= lo_y - box_tol;
		endfunction

		function logic [2:0] contact_of(seg_pair_t p);
			orient_t o1;
			orient_t o2;
			orient_t o3;
			orient_t o4;
			o1 = orientation(p.ax0, p.ay0, p.ax1, p.ay1, p.bx0, p.by0);
			o2 = orientation(p.ax0, p.ay0, p.ax1, p.ay1, p.bx1, p.by1);
			o3 = orientation(p.bx0, p.by0, p.bx1, p.by1, p.ax0, p.ay0);
			o4 = orientation(p.bx0, p.by0, p.bx1, p.by1, p.ax1, p.ay1);
			if (o1 != o2 && o3 != o4) return KIND_CROSS;
			if (o1 == ORI_COL && near_box(p.ax0, p.ay0, p.bx0, p.by0, p.ax1, p.ay1))
				return KIND_B0_ON_A;
			if (o2 == ORI_COL && near_box(p.ax0, p.ay0, p.bx1, p.by1, p.ax1, p.ay1))
				return KIND_B1_ON_A;
			if (o3 == ORI_COL && near_box(p.bx0, p.by0, p.ax0, p.ay0, p.bx1, p.by1))
				return KIND_A0_ON_B;
			if (o4 == ORI_COL && near_box(p.bx0, p.by0, p.ax1, p.ay1, p.bx1, p.by1))
				return KIND_A1_ON_B;
			return KIND_NONE;
		endfunction

		function void note_request(seg_pair_t p);
			pending_kinds.push_back(contact_of(p));
		endfunction

		function void check_result(logic h, logic [2:0] k);
			logic [2:0] want;
			if (pending_kinds.size() == 0) begin
				$display("%0t: result with none pending: expected nothing, got hit %0b kind %0d",
					$time, h, k);
				errors++;
				return;
			end
			want = pending_kinds.pop_front();
			if (h !== (want != KIND_NONE)) begin
				$display("%0t: hit mismatch: expected %0b, got %0b", $time, want != KIND_NONE, h);
				errors++;
			end
			if (k !== want) begin
				$display("%0t: contact_kind mismatch: expected %0d, got %0d", $time, want, k);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	coord_t                a_start_x;
	coord_t                a_start_y;
	coord_t                a_end_x;
	coord_t                a_end_y;
	coord_t                b_start_x;
	coord_t                b_start_y;
	coord_t                b_end_x;
	coord_t                b_end_y;
	logic                  out_valid;
	logic                  out_stall;
	logic                  hit;
	logic [2:0]            contact_kind;

	contact_scoreboard sb = new();
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_off_req;

	segment_pair_collision_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_start_x(a_start_x),
		.a_start_y(a_start_y),
		.a_end_x(a_end_x),
		.a_end_y(a_end_y),
		.b_start_x(b_start_x),
		.b_start_y(b_start_y),
		.b_end_x(b_end_x),
		.b_end_y(b_end_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.contact_kind(contact_kind)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("segment_pair_collision_test test failed");
		$finish;
	end

	// output pacing: random stall bursts, plus one long hold-off on demand
	initial begin : rx_pacing
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (int'($urandom_range(0, 99)) < rx_idle_pct) begin
				n = $urandom_range(1, 19);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(hit, contact_kind);
	end

	function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		seg_pair_t p;
		p.ax0 = coord_t'(ax0);
		p.ay0 = coord_t'(ay0);
		p.ax1 = coord_t'(ax1);
		p.ay1 = coord_t'(ay1);
		p.bx0 = coord_t'(bx0);
		p.by0 = coord_t'(by0);
		p.bx1 = coord_t'(bx1);
		p.by1 = coord_t'(by1);
		return p;
	endfunction

	// mix of raw noise, tiny grids, extremes and pairs built to touch or nearly touch
	function automatic seg_pair_t random_pair();
		int pick;
		int c[8];
		int s0x, s0y, s1x, s1y, ptx, pty, otx, oty;
		int dx, dy, m, k, t;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			foreach (c[i]) c[i] = int'($urandom);
		end else if (pick < 35) begin
			foreach (c[i]) c[i] = int'($urandom_range(0, 16)) - 8;
		end else if (pick < 45) begin
			foreach (c[i]) begin
				case ($urandom_range(0, 4))
					0: c[i] = -32768;
					1: c[i] = 32767;
					2: c[i] = 0;
					3: c[i] = -1;
					default: c[i] = int'($urandom);
				endcase
			end
		end else begin
			s0x = int'($urandom_range(0, 40000)) - 20000;
			s0y = int'($urandom_range(0, 40000)) - 20000;
			dx  = int'($urandom_range(0, 100)) - 50;
			dy  = int'($urandom_range(0, 100)) - 50;
			m   = $urandom_range(1, 20);
			k   = $urandom_range(0, m);
			s1x = s0x + m * dx;
			s1y = s0y + m * dy;
			ptx = s0x + k * dx;
			pty = s0y + k * dy;
			if (pick < 65) begin
				t   = int'($urandom_range(0, 2 * m)) - m / 2;
				otx = s0x + t * dx;
				oty = s0y + t * dy;
			end else begin
				otx = ptx + int'($urandom_range(0, 2000)) - 1000;
				oty = pty + int'($urandom_range(0, 2000)) - 1000;
			end
			if (pick >= 85) begin
				ptx = ptx + int'($urandom_range(0, 6)) - 3;
				pty = pty + int'($urandom_range(0, 6)) - 3;
			end
			if ($urandom_range(0, 1)) begin
				t = s0x; s0x = s1x; s1x = t;
				t = s0y; s0y = s1y; s1y = t;
			end
			case ($urandom_range(0, 3))
				0: c = '{s0x, s0y, s1x, s1y, ptx, pty, otx, oty};
				1: c = '{s0x, s0y, s1x, s1y, otx, oty, ptx, pty};
				2: c = '{ptx, pty, otx, oty, s0x, s0y, s1x, s1y};
				default: c = '{otx, oty, ptx, pty, s0x, s0y, s1x, s1y};
			endcase
		end
		return make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endfunction

	task automatic send_pair(input seg_pair_t p);
		int n;
		@(negedge clk);
		in_valid  <= 1'b1;
		a_start_x <= p.ax0;
		a_start_y <= p.ay0;
		a_end_x   <= p.ax1;
		a_end_y   <= p.ay1;
		b_start_x <= p.bx0;
		b_start_y <= p.by0;
		b_end_x   <= p.bx1;
		b_end_y   <= p.by1;
		do @(posedge clk); while (in_stall);
		sb.note_request(p);
		if (int'($urandom_range(0, 99)) < tx_idle_pct) begin
			n = $urandom_range(1, 19);
			repeat (n) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	task automatic send_random(input int count);
		repeat (count) send_pair(random_pair());
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_kinds.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input longint value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_write_en <= 1'b0;
		if (idx == CFG_DET_TOL)
			sb.det_tol = value;
		else
			sb.box_tol = value;
	endtask

	task automatic set_tolerances(input longint det, input longint box);
		wait_idle();
		write_reg(CFG_DET_TOL, det);
		write_reg(CFG_BOX_TOL, box);
	endtask

	initial begin : stimulus
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = CFG_DET_TOL;
		cfg_data     = '0;
		in_valid     = 1'b0;
		a_start_x    = '0;
		a_start_y    = '0;
		a_end_x      = '0;
		a_end_y      = '0;
		b_start_x    = '0;
		b_start_y    = '0;
		b_end_x      = '0;
		b_end_y      = '0;
		tx_idle_pct  = 10;
		rx_idle_pct  = 10;
		hold_off_req = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero tolerances: only exact zero determinants are collinear
		set_tolerances(0, 0);
		send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
		send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		send_pair(make_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
		send_pair(make_pair(0, 0, 10, 0, 20, 0, 5, 0));
		send_pair(make_pair(0, 0, 5, 0, -5, 0, 10, 0));
		send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
		send_pair(make_pair(0, 0, 5, 0, 10, 0, 20, 0));
		send_pair(make_pair(0, 0, 10, 0, 5, 5, 5, 0));
		send_pair(make_pair(0, 0, 10, 0, 11, 1, 20, 0));
		send_pair(make_pair(0, 0, 0, 0, -5, 0, 5, 0));
		send_pair(make_pair(7, -3, 7, -3, 7, -3, 7, -3));
		send_random(130);

		// small tolerances: determinant and box edges
		tx_idle_pct = 5;
		rx_idle_pct = 30;
		set_tolerances(6, 2);
		send_pair(make_pair(5, 1, 5, 0, 0, 0, 10, 0));
		send_pair(make_pair(0, 0, 1, 0, 0, 2, 0, 40));
		send_pair(make_pair(0, 0, 1, 0, 0, 3, 0, 40));
		send_pair(make_pair(0, 0, 1, 0, 0, 6, 0, 40));
		send_pair(make_pair(0, 0, 1, 0, 0, 5, 0, 40));
		send_random(100);

		// large tolerances (box tolerance at its maximum), no idling
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_tolerances(64'd17179869184, 65535);
		send_random(60);

		// moderate tolerances, then a long output hold-off to back the pipe up
		tx_idle_pct = 20;
		rx_idle_pct = 15;
		set_tolerances($urandom_range(0, 100000), $urandom_range(0, 300));
		send_random(60);
		tx_idle_pct = 0;
		hold_off_req = 1'b1;
		send_random(40);
		tx_idle_pct = 20;
		send_random(50);

		tx_idle_pct = 40;
		rx_idle_pct = 5;
		set_tolerances((longint'($urandom_range(0, 3)) << 32) | longint'($urandom),
			$urandom_range(0, 65535));
		send_random(60);

		// closing stretch without idling
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_tolerances(1, 0);
		send_random(80);

		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_kinds.size() == 0)
			$display("segment_pair_collision_test test passed");
		else
			$display("segment_pair_collision_test test failed");
		$finish;
	end
endmodule
